### hw/rtl/pcm_sample_loop_fetcher_core_assert.svh
// Assertion macros used by the checker file.
`ifndef PCM_SAMPLE_LOOP_FETCHER_CORE_ASSERT_SVH
`define PCM_SAMPLE_LOOP_FETCHER_CORE_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define PSLF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define PSLF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define PSLF_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/pslf_pkg.sv
package pslf_pkg;

    // Field widths of the channels
    localparam int FIELD_W     = 24;
    localparam int SAMPLE_W    = 16;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int OFFSET_BITS_DEF = 24;

    // Offset of unsigned 8-bit data around zero
    localparam logic [BYTE_W-1:0] U8_BIAS = 8'h80;

    typedef enum logic [1:0] {
        FMT_U8     = 2'd0,
        FMT_S8     = 2'd1,
        FMT_S16_LE = 2'd2,
        FMT_S16_BE = 2'd3
    } t_sample_format;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_FORMAT = 3'd0,
        CFG_STEREO        = 3'd1,
        CFG_DATA_BYTES    = 3'd2,
        CFG_LOOP_BASE     = 3'd3,
        CFG_LOOP_LIMIT    = 3'd4,
        CFG_REPEAT        = 3'd5
    } t_cfg_index;

    typedef enum logic {
        OP_FETCH = 1'b0,
        OP_SEEK  = 1'b1
    } t_op;

    typedef struct packed {
        t_sample_format           sample_format;
        logic                     stereo;
        logic [FIELD_W-1:0]       data_bytes;
        logic [FIELD_W-1:0]       loop_base;
        logic [FIELD_W-1:0]       loop_limit;
        logic                     repeat_cfg;
    } t_cfg;

endpackage

### hw/rtl/pslf_intf.sv
// Fetch/seek request channel
interface pslf_fetch_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [pslf_pkg::BYTE_W-1:0]   first_byte;
    logic [pslf_pkg::BYTE_W-1:0]   second_byte;
    logic [pslf_pkg::FIELD_W-1:0]  seek_frame;

    modport source (output valid, op, first_byte, second_byte, seek_frame, input ready);
    modport sink   (input valid, op, first_byte, second_byte, seek_frame, output ready);
endinterface

// Result channel
interface pslf_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pslf_pkg::SAMPLE_W-1:0] sample;
    logic [pslf_pkg::FIELD_W-1:0]         next_offset;
    logic [pslf_pkg::FIELD_W-1:0]         frame_position;
    logic                                 ended;

    modport source (output valid, sample, next_offset, frame_position, ended, input ready);
    modport sink   (input valid, sample, next_offset, frame_position, ended, output ready);
endinterface

// Register write channel
interface pslf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pslf_pkg::CFG_IDX_W-1:0]   index;
    logic [pslf_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/pcm_sample_loop_fetcher_core.sv
// Channel    Dir   Role    Request contents
// i_fetch    in    sink    op, first_byte, second_byte, seek_frame
// o_result   out   source  sample, next_offset, frame_position, ended
// i_cfg      in    sink    index, data (register write, always ready)
//
// One request per cycle sustained while results are taken; a result becomes valid
// when its request moves from the input register into the result register.
// The offset update and sample conversion sit between those two registers.
// Synchronous active-low reset clears the offset, configuration and valid flags.
// A stalled result holds its register; the input register still takes one
// further request, after which i_fetch.ready drops until the result drains.
module pcm_sample_loop_fetcher_core #(
    parameter int OFFSET_BITS = pslf_pkg::OFFSET_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pslf_fetch_if.sink            i_fetch,
    pslf_result_if.source         o_result,
    pslf_cfg_if.sink              i_cfg
);
    import pslf_pkg::*;

    // Configuration registers
    t_cfg                   r_cfg;
    t_cfg                   n_cfg;

    // Input register
    logic                   r_in_valid;
    logic                   r_in_op;
    logic [BYTE_W-1:0]      r_in_first_byte;
    logic [BYTE_W-1:0]      r_in_second_byte;
    logic [FIELD_W-1:0]     r_in_seek_frame;

    // Stream state
    logic [OFFSET_BITS-1:0] r_byte_offset;

    // Result register
    logic                   r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic [FIELD_W-1:0]     r_out_next_offset;
    logic [FIELD_W-1:0]     r_out_frame_position;
    logic                   r_out_ended;

    logic                   advance;
    logic                   in_take;
    logic [OFFSET_BITS-1:0] n_byte_offset;
    logic [FIELD_W-1:0]     n_frame_position;
    logic                   n_ended;
    logic                   n_silent;
    logic signed [SAMPLE_W-1:0] n_sample;

    // Move a request into the result register when that register is free or being taken
    assign advance       = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_fetch.ready = !r_in_valid || advance;
    assign in_take       = i_fetch.valid && i_fetch.ready;
    assign i_cfg.ready   = 1'b1;

    // Decode register writes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (t_cfg_index'(i_cfg.index))
                CFG_SAMPLE_FORMAT: n_cfg.sample_format = t_sample_format'(i_cfg.data[1:0]);
                CFG_STEREO:        n_cfg.stereo        = i_cfg.data[0];
                CFG_DATA_BYTES:    n_cfg.data_bytes    = i_cfg.data[FIELD_W-1:0];
                CFG_LOOP_BASE:     n_cfg.loop_base     = i_cfg.data[FIELD_W-1:0];
                CFG_LOOP_LIMIT:    n_cfg.loop_limit    = i_cfg.data[FIELD_W-1:0];
                CFG_REPEAT:        n_cfg.repeat_cfg    = i_cfg.data[0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Offset update
    pslf_advance #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_advance (
        .i_cfg            (r_cfg),
        .i_offset         (r_byte_offset),
        .i_op             (r_in_op),
        .i_seek_frame     (r_in_seek_frame),
        .o_next           (n_byte_offset),
        .o_frame_position (n_frame_position),
        .o_ended          (n_ended),
        .o_silent         (n_silent)
    );

    // Sample conversion
    pslf_convert u_convert (
        .i_format      (r_cfg.sample_format),
        .i_silent      (n_silent),
        .i_first_byte  (r_in_first_byte),
        .i_second_byte (r_in_second_byte),
        .o_sample      (n_sample)
    );

    // Input register: load on acceptance, drain on advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op          <= i_fetch.op;
            r_in_first_byte  <= i_fetch.first_byte;
            r_in_second_byte <= i_fetch.second_byte;
            r_in_seek_frame  <= i_fetch.seek_frame;
        end
    end

    // Offset state advances with each request that completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_offset <= '0;
        end else if (advance) begin
            r_byte_offset <= n_byte_offset;
        end
    end

    // Result register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_sample         <= n_sample;
            r_out_next_offset    <= FIELD_W'(n_byte_offset);
            r_out_frame_position <= n_frame_position;
            r_out_ended          <= n_ended;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.sample         = r_out_sample;
    assign o_result.next_offset    = r_out_next_offset;
    assign o_result.frame_position = r_out_frame_position;
    assign o_result.ended          = r_out_ended;

endmodule

### hw/rtl/pslf_convert.sv
module pslf_convert (
    input  pslf_pkg::t_sample_format                 i_format,
    input  logic                                     i_silent,
    input  logic [pslf_pkg::BYTE_W-1:0]              i_first_byte,
    input  logic [pslf_pkg::BYTE_W-1:0]              i_second_byte,
    output logic signed [pslf_pkg::SAMPLE_W-1:0]     o_sample
);
    import pslf_pkg::*;

    logic [SAMPLE_W-1:0] raw;

    // Widen the element to 16 bits; 8-bit data lands in the upper byte
    always_comb begin
        case (i_format)
            FMT_U8:     raw = {i_first_byte ^ U8_BIAS, {BYTE_W{1'b0}}};
            FMT_S8:     raw = {i_first_byte, {BYTE_W{1'b0}}};
            FMT_S16_LE: raw = {i_second_byte, i_first_byte};
            FMT_S16_BE: raw = {i_first_byte, i_second_byte};
            default:    raw = '0;
        endcase
    end

    // Drop to silence for seeks and short elements
    assign o_sample = i_silent ? '0 : $signed(raw);

endmodule

### hw/rtl/pslf_advance.sv
module pslf_advance #(
    parameter int OFFSET_BITS = pslf_pkg::OFFSET_BITS_DEF
) (
    input  pslf_pkg::t_cfg                  i_cfg,
    input  logic [OFFSET_BITS-1:0]          i_offset,
    input  logic                            i_op,
    input  logic [pslf_pkg::FIELD_W-1:0]    i_seek_frame,
    output logic [OFFSET_BITS-1:0]          o_next,
    output logic [pslf_pkg::FIELD_W-1:0]    o_frame_position,
    output logic                            o_ended,
    output logic                            o_silent
);
    import pslf_pkg::*;

    // Compare width wide enough for offset plus element without overflow
    localparam int CW = ((OFFSET_BITS > FIELD_W) ? OFFSET_BITS : FIELD_W) + 1;
    localparam int SEEK_W = FIELD_W + 2;

    logic [1:0]         elem;
    logic [1:0]         frame_shift;
    logic [CW-1:0]      off_x;
    logic [CW-1:0]      dl_x;
    logic [CW-1:0]      ls_x;
    logic [CW-1:0]      le_x;
    logic [CW-1:0]      sum;
    logic               past_end;
    logic [1:0]         avail_end;
    logic [CW-1:0]      next_end;
    logic               loop_hit;
    logic [1:0]         avail;
    logic [CW-1:0]      next_fetch;
    logic [FIELD_W-1:0] frames_total;
    logic [SEEK_W-1:0]  seek_bytes;
    logic               seek_ok;

    assign elem        = i_cfg.sample_format[1] ? 2'd2 : 2'd1;
    assign frame_shift = {1'b0, i_cfg.sample_format[1]} + {1'b0, i_cfg.stereo};

    assign off_x = CW'(i_offset);
    assign dl_x  = CW'(i_cfg.data_bytes);
    assign ls_x  = CW'(i_cfg.loop_base);
    assign le_x  = CW'(i_cfg.loop_limit);
    assign sum   = off_x + CW'(elem);

    // Data end: cut the readable bytes, then wrap or park
    always_comb begin
        past_end  = (sum >= dl_x);
        avail_end = elem;
        next_end  = sum;
        if (past_end) begin
            avail_end = (off_x < dl_x) ? 2'(dl_x - off_x) : 2'd0;
            next_end  = i_cfg.repeat_cfg ? '0 : dl_x;
        end
    end

    // When repeating, the loop end overrides the data end
    always_comb begin
        loop_hit   = i_cfg.repeat_cfg && (off_x < le_x) && ((off_x + CW'(avail_end)) >= le_x);
        avail      = loop_hit ? 2'(le_x - off_x) : avail_end;
        next_fetch = loop_hit ? ls_x : next_end;
    end

    // Seek only to a frame inside the data
    assign frames_total = i_cfg.data_bytes >> frame_shift;
    assign seek_ok      = (i_seek_frame < frames_total);
    assign seek_bytes   = SEEK_W'(i_seek_frame) << frame_shift;

    always_comb begin
        if (i_op == OP_SEEK) begin
            o_next   = seek_ok ? OFFSET_BITS'(seek_bytes) : i_offset;
            o_silent = 1'b1;
        end else begin
            o_next   = OFFSET_BITS'(next_fetch);
            o_silent = (avail < elem);
        end
    end

    // Position and end flag from the new offset
    assign o_frame_position = FIELD_W'(o_next >> frame_shift);
    assign o_ended          = !i_cfg.repeat_cfg && (CW'(o_next) >= dl_x);

endmodule

### hw/rtl/pslf_checker.sv
`include "pcm_sample_loop_fetcher_core_assert.svh"

module pslf_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_ready,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [pslf_pkg::FIELD_W-1:0]  i_next_offset,
    input  logic [pslf_pkg::FIELD_W-1:0]  i_frame_position
);
    import pslf_pkg::*;

    // Reset leaves no result pending
    `PSLF_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_out_valid, "result valid after reset")

    // A pending result stays until taken
    `PSLF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")

    // Requests are refused only behind a stalled result
    `PSLF_ASSERT_NOW(a_in_backpressure, i_clk, i_rst_n, !i_in_ready, i_out_valid && !i_out_ready, "request refused without output stall")

    // Frame index never exceeds the byte offset
    `PSLF_ASSERT_NOW(a_frame_le_offset, i_clk, i_rst_n, i_out_valid, i_frame_position <= i_next_offset, "frame position beyond byte offset")

endmodule

bind pcm_sample_loop_fetcher_core pslf_checker u_pslf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_fetch.ready),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_next_offset    (o_result.next_offset),
    .i_frame_position (o_result.frame_position)
);
